>>> src/sise_pkg.sv
// ----------------------------------------------------------------------------
// sise_pkg
// shared command codes, status codes and sequencer states of the set engine
// ----------------------------------------------------------------------------
package sise_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_UNION   = 3'd2,
    CMD_INTER   = 3'd3,
    CMD_DIFF    = 3'd4,
    CMD_COMPARE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_SCAN,
    S_COPY,
    S_TEST,
    S_MOVE,
    S_FINAL
  } state_e;

  localparam int unsigned OutWidth  = 16;
  localparam int unsigned SizeWidth = 5;

endpackage

>>> src/small_integer_set_engine_top.sv
// ----------------------------------------------------------------------------
// small_integer_set_engine_top
// two small duplicate-free sets with insert, remove, union, intersection,
// difference and compare, built from rows of matching cells
// ----------------------------------------------------------------------------
// Usage: a command beat (cmd, which_set, element) enters on in_valid_i /
// in_ready_o. Every command gives one or more result beats on out_valid_o /
// out_ready_i; last_o marks the final beat of a command. One command is
// worked on at a time; in_ready_o rises again once the final beat sits in
// the output register, so the next command overlaps with its delivery.
// Insert, unused codes and a remove that misses answer from the exec state;
// a remove that hits first moves the last entry into the freed slot.
// Intersection and compare scan each entry of A, union each entry of A
// and then of B, before the final beat. Difference first copies A into a
// work row, tests each work slot (a hit moves the last work entry into
// it and the slot is tested again), then streams the remaining slots.
// The rate is set by the single read port of each row: one entry is looked
// up per cycle against a whole row of cells in parallel. A stalled receiver
// holds the output register and the scan simply waits. Reset empties both
// sets; stored elements are not cleared.
// ----------------------------------------------------------------------------
module small_integer_set_engine_top
  import sise_pkg::*;
#(
  parameter int unsigned SET_SIZE   = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic                  which_set_i,
  input  logic signed [15:0]    element_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    value_out_o,
  output logic                  value_valid_o,
  output logic                  last_o,
  output logic [1:0]            status_o,
  output logic                  is_subset_o,
  output logic                  is_equal_o,
  output logic [SizeWidth-1:0]  size_a_o,
  output logic [SizeWidth-1:0]  size_b_o
);

  localparam int unsigned IW = $clog2(SET_SIZE);
  localparam int unsigned CW = $clog2(SET_SIZE + 1);

  state_e state_q, state_d;

  logic [2:0]            cmd_q, cmd_d;
  logic                  which_q, which_d;
  logic [ELEM_WIDTH-1:0] elem_q, elem_d;
  logic [CW-1:0]         cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, cnt_w_q, cnt_w_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         ridx_q, ridx_d;
  logic                  phase_q, phase_d;
  logic                  all_q, all_d;
  logic                  pend_v_q, pend_v_d;
  logic [ELEM_WIDTH-1:0] pend_q, pend_d;

  logic                  ov_q, ov_d;
  logic [OutWidth-1:0]   oval_q, oval_d;
  logic                  ovv_q, ovv_d, olast_q, olast_d;
  logic [1:0]            ost_q, ost_d;
  logic                  osub_q, osub_d, oeq_q, oeq_d;

  // row signals
  logic [ELEM_WIDTH-1:0]                key_a, key_b, rd_a, rd_b, rd_w;
  logic [ELEM_WIDTH-1:0]                wr_data, tgt_rd;
  logic [IW-1:0]                        rd_idx_a, rd_idx_b, rd_idx_w, wr_idx;
  logic [IW-1:0]                        last_a, last_b, last_w, hidx_a, hidx_b, hidx_w;
  logic                                 wr_a, wr_b, wr_w, ld_w;
  logic                                 hit_a, hit_b, hit_w;
  logic [SET_SIZE-1:0][ELEM_WIDTH-1:0]  ent_a, ent_b, ent_w;

  // decode
  logic                  out_free, in_fire;
  logic                  tgt_hit, src_end, emit, test_hit;
  logic [CW-1:0]         tgt_cnt, src_cnt, cnt_a_m1, cnt_b_m1, cnt_w_m1;
  logic [ELEM_WIDTH-1:0] src_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !ov_q || out_ready_i;

  assign cnt_a_m1 = cnt_a_q - CW'(1);
  assign cnt_b_m1 = cnt_b_q - CW'(1);
  assign cnt_w_m1 = cnt_w_q - CW'(1);
  assign last_a   = cnt_a_m1[IW-1:0];
  assign last_b   = cnt_b_m1[IW-1:0];
  assign last_w   = cnt_w_m1[IW-1:0];

  assign tgt_hit = which_q ? hit_b : hit_a;
  assign tgt_cnt = which_q ? cnt_b_q : cnt_a_q;
  assign tgt_rd  = which_q ? rd_b : rd_a;

  assign rd_idx_a = (state_q == S_REMOVE) ? last_a : idx_q[IW-1:0];
  assign rd_idx_b = (state_q == S_REMOVE) ? last_b : idx_q[IW-1:0];
  assign rd_idx_w = (state_q == S_MOVE) ? last_w : idx_q[IW-1:0];

  // search keys: the command element, or an entry of the row being scanned
  assign key_a = (state_q == S_SCAN) ? rd_b : elem_q;
  always_comb begin
    unique case (state_q)
      S_SCAN:  key_b = rd_a;
      S_TEST:  key_b = rd_w;
      default: key_b = elem_q;
    endcase
  end

  always_comb begin
    src_data = rd_a;
    src_cnt  = cnt_a_q;
    test_hit = hit_b;
    emit     = 1'b0;
    unique case (cmd_q)
      CMD_UNION: begin
        if (phase_q) begin
          src_data = rd_b;
          src_cnt  = cnt_b_q;
          test_hit = hit_a;
          emit     = !hit_a;
        end else begin
          emit = 1'b1;
        end
      end
      CMD_INTER: emit = hit_b;
      CMD_DIFF: begin
        src_data = rd_w;
        src_cnt  = cnt_w_q;
        emit     = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  assign src_end = (idx_q >= src_cnt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_UNION, CMD_INTER, CMD_COMPARE: state_d = S_SCAN;
            CMD_DIFF:                          state_d = S_COPY;
            default:                           state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = (cmd_q == CMD_REMOVE && tgt_hit) ? S_REMOVE : S_IDLE;
        end
      end
      S_REMOVE: if (out_free) state_d = S_IDLE;
      S_SCAN: begin
        if (out_free && src_end && !(cmd_q == CMD_UNION && !phase_q)) begin
          state_d = S_FINAL;
        end
      end
      S_COPY: state_d = S_TEST;
      S_TEST: begin
        if (idx_q >= cnt_w_q) begin
          state_d = S_SCAN;
        end else if (hit_b) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE:  state_d = S_TEST;
      S_FINAL: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d    = cmd_q;
    which_d  = which_q;
    elem_d   = elem_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    cnt_w_d  = cnt_w_q;
    idx_d    = idx_q;
    ridx_d   = ridx_q;
    phase_d  = phase_q;
    all_d    = all_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    ov_d     = ov_q && !out_ready_i;
    oval_d   = oval_q;
    ovv_d    = ovv_q;
    olast_d  = olast_q;
    ost_d    = ost_q;
    osub_d   = osub_q;
    oeq_d    = oeq_q;
    wr_a     = 1'b0;
    wr_b     = 1'b0;
    wr_w     = 1'b0;
    ld_w     = 1'b0;
    wr_idx   = (state_q == S_REMOVE) ? ridx_q : tgt_cnt[IW-1:0];
    wr_data  = (state_q == S_REMOVE) ? tgt_rd : elem_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d    = cmd_i;
          which_d  = which_set_i;
          elem_d   = ELEM_WIDTH'(element_i);
          idx_d    = '0;
          phase_d  = 1'b0;
          all_d    = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oval_d  = '0;
          ovv_d   = 1'b0;
          olast_d = 1'b1;
          osub_d  = 1'b0;
          oeq_d   = 1'b0;
          ost_d   = ST_IGNORED;
          if (cmd_q == CMD_INSERT) begin
            if (tgt_hit) begin
              ost_d = ST_IGNORED;
            end else if (tgt_cnt >= CW'(SET_SIZE)) begin
              ost_d = ST_FULL;
            end else begin
              ost_d = ST_DONE;
              if (which_q) begin
                wr_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end else begin
                wr_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end
            end
          end else if (cmd_q == CMD_REMOVE && tgt_hit) begin
            // the beat goes out once the last entry has moved in
            ov_d   = ov_q && !out_ready_i;
            ridx_d = which_q ? hidx_b : hidx_a;
          end
        end
      end
      S_REMOVE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oval_d  = '0;
          ovv_d   = 1'b0;
          olast_d = 1'b1;
          osub_d  = 1'b0;
          oeq_d   = 1'b0;
          ost_d   = ST_DONE;
          if (which_q) begin
            wr_b    = 1'b1;
            cnt_b_d = cnt_b_m1;
          end else begin
            wr_a    = 1'b1;
            cnt_a_d = cnt_a_m1;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (src_end) begin
            if (cmd_q == CMD_UNION && !phase_q) begin
              phase_d = 1'b1;
              idx_d   = '0;
            end
          end else begin
            idx_d = idx_q + CW'(1);
            if (cmd_q == CMD_COMPARE && !test_hit) begin
              all_d = 1'b0;
            end
            if (emit) begin
              // hold one element back so the final beat can carry last
              if (pend_v_q) begin
                ov_d    = 1'b1;
                oval_d  = OutWidth'(pend_q);
                ovv_d   = 1'b1;
                olast_d = 1'b0;
                ost_d   = ST_DONE;
                osub_d  = 1'b0;
                oeq_d   = 1'b0;
              end
              pend_v_d = 1'b1;
              pend_d   = src_data;
            end
          end
        end
      end
      S_COPY: begin
        ld_w    = 1'b1;
        cnt_w_d = cnt_a_q;
        idx_d   = '0;
      end
      S_TEST: begin
        if (idx_q >= cnt_w_q) begin
          idx_d = '0;
        end else if (!hit_b) begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_MOVE: begin
        // work slot takes the last work entry and is tested again
        wr_w    = 1'b1;
        cnt_w_d = cnt_w_m1;
      end
      S_FINAL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          ost_d   = ST_DONE;
          oval_d  = '0;
          ovv_d   = 1'b0;
          osub_d  = 1'b0;
          oeq_d   = 1'b0;
          if (cmd_q == CMD_COMPARE) begin
            osub_d = all_q && (cnt_a_q <= cnt_b_q);
            oeq_d  = all_q && (cnt_a_q == cnt_b_q);
          end else if (pend_v_q) begin
            oval_d = OutWidth'(pend_q);
            ovv_d  = 1'b1;
          end
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      cnt_w_q  <= '0;
      idx_q    <= '0;
      phase_q  <= 1'b0;
      all_q    <= 1'b0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      cnt_w_q  <= cnt_w_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      all_q    <= all_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    which_q <= which_d;
    elem_q  <= elem_d;
    ridx_q  <= ridx_d;
    pend_q  <= pend_d;
    oval_q  <= oval_d;
    ovv_q   <= ovv_d;
    olast_q <= olast_d;
    ost_q   <= ost_d;
    osub_q  <= osub_d;
    oeq_q   <= oeq_d;
  end

  sise_row #(
    .SET_SIZE(SET_SIZE), .ELEM_WIDTH(ELEM_WIDTH), .IW(IW), .CW(CW)
  ) u_row_a (
    .clk_i    (clk_i),
    .count_i  (cnt_a_q),
    .key_i    (key_a),
    .wr_en_i  (wr_a),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .ld_en_i  (1'b0),
    .ld_data_i(ent_b),
    .rd_idx_i (rd_idx_a),
    .rd_data_o(rd_a),
    .entries_o(ent_a),
    .hit_o    (hit_a),
    .hit_idx_o(hidx_a)
  );

  sise_row #(
    .SET_SIZE(SET_SIZE), .ELEM_WIDTH(ELEM_WIDTH), .IW(IW), .CW(CW)
  ) u_row_b (
    .clk_i    (clk_i),
    .count_i  (cnt_b_q),
    .key_i    (key_b),
    .wr_en_i  (wr_b),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .ld_en_i  (1'b0),
    .ld_data_i(ent_a),
    .rd_idx_i (rd_idx_b),
    .rd_data_o(rd_b),
    .entries_o(ent_b),
    .hit_o    (hit_b),
    .hit_idx_o(hidx_b)
  );

  // work row for difference, loaded from row a as a whole
  sise_row #(
    .SET_SIZE(SET_SIZE), .ELEM_WIDTH(ELEM_WIDTH), .IW(IW), .CW(CW)
  ) u_row_w (
    .clk_i    (clk_i),
    .count_i  (cnt_w_q),
    .key_i    (elem_q),
    .wr_en_i  (wr_w),
    .wr_idx_i (idx_q[IW-1:0]),
    .wr_data_i(rd_w),
    .ld_en_i  (ld_w),
    .ld_data_i(ent_a),
    .rd_idx_i (rd_idx_w),
    .rd_data_o(rd_w),
    .entries_o(ent_w),
    .hit_o    (hit_w),
    .hit_idx_o(hidx_w)
  );

  assign out_valid_o   = ov_q;
  assign value_out_o   = oval_q;
  assign value_valid_o = ovv_q;
  assign last_o        = olast_q;
  assign status_o      = ost_q;
  assign is_subset_o   = osub_q;
  assign is_equal_o    = oeq_q;
  assign size_a_o      = SizeWidth'(cnt_a_q);
  assign size_b_o      = SizeWidth'(cnt_b_q);

endmodule

>>> src/sise_cell.sv
// ----------------------------------------------------------------------------
// sise_cell
// one slot of a set: holds an element and compares it against the search key
// ----------------------------------------------------------------------------
module sise_cell #(
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  ld_en_i,
  input  logic [ELEM_WIDTH-1:0] ld_data_i,
  input  logic                  wr_en_i,
  input  logic [ELEM_WIDTH-1:0] wr_data_i,
  input  logic                  valid_i,
  input  logic [ELEM_WIDTH-1:0] key_i,
  output logic [ELEM_WIDTH-1:0] entry_o,
  output logic                  hit_o
);

  logic [ELEM_WIDTH-1:0] entry_q;

  // bulk copy from the neighbouring row has priority over a single write
  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      entry_q <= ld_data_i;
    end else if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = valid_i && (entry_q == key_i);

endmodule

>>> src/sise_row.sv
// ----------------------------------------------------------------------------
// sise_row
// row of set cells with one write port, one read port and a key match
// ----------------------------------------------------------------------------
module sise_row #(
  parameter int unsigned SET_SIZE   = 16,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned IW         = $clog2(SET_SIZE),
  parameter int unsigned CW         = $clog2(SET_SIZE + 1)
) (
  input  logic                                 clk_i,
  input  logic [CW-1:0]                        count_i,
  input  logic [ELEM_WIDTH-1:0]                key_i,
  input  logic                                 wr_en_i,
  input  logic [IW-1:0]                        wr_idx_i,
  input  logic [ELEM_WIDTH-1:0]                wr_data_i,
  input  logic                                 ld_en_i,
  input  logic [SET_SIZE-1:0][ELEM_WIDTH-1:0]  ld_data_i,
  input  logic [IW-1:0]                        rd_idx_i,
  output logic [ELEM_WIDTH-1:0]                rd_data_o,
  output logic [SET_SIZE-1:0][ELEM_WIDTH-1:0] entries_o,
  output logic                                 hit_o,
  output logic [IW-1:0]                        hit_idx_o
);

  logic [SET_SIZE-1:0] hits;

  for (genvar g = 0; g < SET_SIZE; g++) begin : g_cell
    sise_cell #(
      .ELEM_WIDTH(ELEM_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .ld_en_i  (ld_en_i),
      .ld_data_i(ld_data_i[g]),
      .wr_en_i  (wr_en_i && (wr_idx_i == IW'(g))),
      .wr_data_i(wr_data_i),
      .valid_i  (CW'(g) < count_i),
      .key_i    (key_i),
      .entry_o  (entries_o[g]),
      .hit_o    (hits[g])
    );
  end

  assign rd_data_o = entries_o[rd_idx_i];
  assign hit_o     = |hits;

  // sets hold no duplicates, so at most one cell matches
  always_comb begin
    hit_idx_o = '0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if (hits[i]) begin
        hit_idx_o = hit_idx_o | IW'(i);
      end
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives command beats into the set engine, keeps its own copy of both sets,
// predicts every result beat and checks each one as it leaves the block
// ----------------------------------------------------------------------------
module testbench
  import sise_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [15:0] value;
    logic        vvalid;
    logic        last;
    logic [1:0]  status;
    logic        subset;
    logic        equal;
    logic [4:0]  size_a;
    logic [4:0]  size_b;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] cmd_i = '0;
  logic which_set_i = 1'b0;
  logic signed [15:0] element_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] value_out_o;
  logic value_valid_o, last_o, is_subset_o, is_equal_o;
  logic [1:0] status_o;
  logic [SizeWidth-1:0] size_a_o, size_b_o;

  small_integer_set_engine_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the two sets
  logic [15:0] set_a [Depth];
  logic [15:0] set_b [Depth];
  int unsigned cnt_a, cnt_b;
  beat_t pending_beats [$];
  bit failed = 1'b0;
  bit stall_free = 1'b0;
  int unsigned cycles = 0;

  function automatic bit member(input logic [15:0] s [Depth], input int unsigned n,
                                input logic [15:0] v);
    for (int i = 0; i < n; i++) if (s[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic beat_t mk(input logic [15:0] v, input bit vv, input bit lst,
                               input logic [1:0] st, input bit sub, input bit eq);
    beat_t b;
    b.value = vv ? v : '0;
    b.vvalid = vv;
    b.last = lst;
    b.status = st;
    b.subset = sub;
    b.equal = eq;
    b.size_a = cnt_a[4:0];
    b.size_b = cnt_b[4:0];
    return b;
  endfunction

  task automatic predict_command(input logic [2:0] cmd, input bit which,
                                 input logic [15:0] elem);
    logic [15:0] res [$];
    logic [15:0] work [$];
    logic [1:0] st;
    bit all;
    int unsigned i;
    st = ST_IGNORED;
    all = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (which ? member(set_b, cnt_b, elem) : member(set_a, cnt_a, elem)) begin
          st = ST_IGNORED;
        end else if ((which ? cnt_b : cnt_a) >= Depth) begin
          st = ST_FULL;
        end else if (which) begin
          set_b[cnt_b] = elem; cnt_b++; st = ST_DONE;
        end else begin
          set_a[cnt_a] = elem; cnt_a++; st = ST_DONE;
        end
        pending_beats.push_back(mk('0, 0, 1, st, 0, 0));
      end
      CMD_REMOVE: begin
        if (which) begin
          for (i = 0; i < cnt_b; i++) if (set_b[i] == elem) begin
            set_b[i] = set_b[cnt_b-1]; cnt_b--; st = ST_DONE; break;
          end
        end else begin
          for (i = 0; i < cnt_a; i++) if (set_a[i] == elem) begin
            set_a[i] = set_a[cnt_a-1]; cnt_a--; st = ST_DONE; break;
          end
        end
        pending_beats.push_back(mk('0, 0, 1, st, 0, 0));
      end
      CMD_UNION, CMD_INTER, CMD_DIFF: begin
        if (cmd == CMD_UNION) begin
          for (i = 0; i < cnt_a; i++) res.push_back(set_a[i]);
          for (i = 0; i < cnt_b; i++)
            if (!member(set_a, cnt_a, set_b[i])) res.push_back(set_b[i]);
        end else if (cmd == CMD_INTER) begin
          for (i = 0; i < cnt_a; i++)
            if (member(set_b, cnt_b, set_a[i])) res.push_back(set_a[i]);
        end else begin
          // swap-last removal, same slot checked again
          for (i = 0; i < cnt_a; i++) work.push_back(set_a[i]);
          i = 0;
          while (i < work.size()) begin
            if (member(set_b, cnt_b, work[i])) begin
              work[i] = work[work.size()-1];
              void'(work.pop_back());
            end else i++;
          end
          res = work;
        end
        if (res.size() == 0) pending_beats.push_back(mk('0, 0, 1, ST_DONE, 0, 0));
        foreach (res[k])
          pending_beats.push_back(mk(res[k], 1, k == res.size()-1, ST_DONE, 0, 0));
      end
      CMD_COMPARE: begin
        for (i = 0; i < cnt_a; i++)
          if (!member(set_b, cnt_b, set_a[i])) all = 1'b0;
        pending_beats.push_back(mk('0, 0, 1, ST_DONE, all && cnt_a <= cnt_b,
                                   all && cnt_a == cnt_b));
      end
      default: pending_beats.push_back(mk('0, 0, 1, ST_IGNORED, 0, 0));
    endcase
  endtask

  // valid stays up between back-to-back beats and drops only for an idle gap
  task automatic send_command(input logic [2:0] cmd, input bit which,
                              input logic [15:0] elem);
    int unsigned gap;
    gap = 0;
    while (!stall_free && $urandom_range(99) < 20) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= cmd;
    which_set_i <= which;
    element_i <= elem;
    in_valid_i <= 1'b1;
    predict_command(cmd, which, elem);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver side stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_ready_i <= stall_free || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{value_out_o, value_valid_o, last_o, status_o, is_subset_o, is_equal_o,
              size_a_o, size_b_o};
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_beats.pop_front();
        if (got.value != want.value)
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
        if (got.vvalid != want.vvalid)
          $display("%0t: value_valid expected %b actual %b", $time, want.vvalid, got.vvalid);
        if (got.last != want.last)
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        if (got.status != want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.subset != want.subset)
          $display("%0t: is_subset expected %b actual %b", $time, want.subset, got.subset);
        if (got.equal != want.equal)
          $display("%0t: is_equal expected %b actual %b", $time, want.equal, got.equal);
        if (got.size_a != want.size_a)
          $display("%0t: size_a expected %0d actual %0d", $time, want.size_a, got.size_a);
        if (got.size_b != want.size_b)
          $display("%0t: size_b expected %0d actual %0d", $time, want.size_b, got.size_b);
        if (got != want) failed = 1'b1;
      end
    end
    if (cycles > CycleLimit) begin
      $display("FAIL small_integer_set_engine_top");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value(input bit from_b);
    // mostly draw from a small pool so sets overlap
    if ($urandom_range(3) == 0) return 16'($urandom);
    if (from_b && cnt_b > 0 && $urandom_range(1)) return set_b[$urandom_range(cnt_b-1)];
    if (!from_b && cnt_a > 0 && $urandom_range(1)) return set_a[$urandom_range(cnt_a-1)];
    return 16'(int'($urandom_range(12)) - 6);
  endfunction

  task automatic test_directed();
    send_command(CMD_UNION, 0, '0);       // empty result
    send_command(CMD_COMPARE, 0, '0);     // empty sets equal
    send_command(CMD_REMOVE, 0, 16'h7fff); // absent
    send_command(CMD_INSERT, 0, 16'h8000);
    send_command(CMD_INSERT, 0, 16'h7fff);
    send_command(CMD_INSERT, 0, 16'h8000); // present
    send_command(CMD_INSERT, 1, 16'h7fff);
    send_command(CMD_INSERT, 1, 16'hffff);
    send_command(CMD_UNION, 0, '0);
    send_command(CMD_INTER, 0, '0);
    send_command(CMD_DIFF, 0, '0);
    send_command(CMD_COMPARE, 0, '0);
    send_command(3'd6, 1, 16'h1234);
    send_command(3'd7, 0, 16'h4321);
    for (int i = 0; i < 17; i++) send_command(CMD_INSERT, 1, 16'(i * 3)); // fills b
    send_command(CMD_REMOVE, 1, 16'h0000);
    send_command(CMD_REMOVE, 0, 16'h8000);
  endtask

  task automatic test_fill_and_drain();
    stall_free = 1'b1;
    for (int i = 0; i < 17; i++) send_command(CMD_INSERT, 0, 16'(i * 3)); // a full
    send_command(CMD_UNION, 0, '0);
    send_command(CMD_DIFF, 0, '0);
    send_command(CMD_COMPARE, 0, '0);
    stall_free = 1'b0;
    for (int i = 0; i < 17; i++)
      send_command(CMD_REMOVE, 1'($urandom_range(1)), 16'(i * 3));
  endtask

  task automatic test_random();
    logic [2:0] cmd;
    bit w;
    for (int n = 0; n < 60; n++) begin
      stall_free = (n >= 20 && n < 40);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: cmd = CMD_INSERT;
        7, 8, 9, 10: cmd = CMD_REMOVE;
        11, 12: cmd = CMD_UNION;
        13, 14: cmd = CMD_INTER;
        15, 16: cmd = CMD_DIFF;
        17, 18: cmd = CMD_COMPARE;
        default: cmd = 3'($urandom_range(7));
      endcase
      w = 1'($urandom_range(1));
      send_command(cmd, w, pick_value(w));
    end
    stall_free = 1'b0;
  endtask

  initial begin
    cnt_a = 0;
    cnt_b = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (!failed) begin
      $display("PASS small_integer_set_engine_top");
    end else begin
      $display("FAIL small_integer_set_engine_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/sise_pkg.sv
src/sise_cell.sv
src/sise_row.sv
src/small_integer_set_engine_top.sv
verif/testbench.sv
